// ----- hdl/rvx_pkg.sv -----
`timescale 1ns / 1ps
package rvx_pkg;
  localparam int PC_BITS = 16;
  localparam logic [4:0] OP_LI = 5'd0, OP_LW = 5'd1, OP_SW = 5'd2, OP_ADD = 5'd3,
    OP_AND = 5'd4, OP_DIV = 5'd5, OP_MUL = 5'd6, OP_REM = 5'd7, OP_OR = 5'd8,
    OP_SLL = 5'd9, OP_SRL = 5'd10, OP_SUB = 5'd11, OP_XOR = 5'd12, OP_ADDI = 5'd13,
    OP_ANDI = 5'd14, OP_ORI = 5'd15, OP_SLLI = 5'd16, OP_SRLI = 5'd17,
    OP_XORI = 5'd18, OP_BEQ = 5'd19, OP_BNE = 5'd20;
  localparam logic [4:0] SHAMT_MASK = 5'h1F;

  typedef struct packed {
    logic [4:0]  operation;
    logic [4:0]  dest_reg;
    logic [4:0]  src1_reg;
    logic [4:0]  src2_reg;
    logic signed [31:0] immediate;
  } in_item_t;

  typedef struct packed {
    logic [17:0] fetch_address;
    logic        data_access_valid;
    logic [31:0] data_address;
    logic        write_valid;
    logic [4:0]  write_index;
    logic [31:0] write_value;
    logic [15:0] next_pc;
    logic        halted;
  } out_item_t;
endpackage

// ----- hdl/rvx_stream_if.sv -----
`timescale 1ns / 1ps
interface rvx_in_if;
  logic valid;
  logic ready;
  rvx_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rvx_out_if;
  logic valid;
  logic ready;
  rvx_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/rv32_subset_execute_unit.sv -----
`timescale 1ns / 1ps
// Most instructions go through a synchronous register file read, then execute, before
// the result is registered; div and rem run through a radix-2 divider after the read.
// The unit takes no new item until it has finished the last one and is back in idle;
// div and rem keep it busy for the whole division.
// A new item is accepted only while the result register is empty or being emptied.
// Reset (rst, synchronous) clears pc, program_length and the 32 register valid bits.
module rv32_subset_execute_unit (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [15:0] cfg_wdata,
  rvx_in_if.sink    in_ch,
  rvx_out_if.source out_ch
);
  import rvx_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0, S_EXEC = 2'd1, S_DIV = 2'd2;

  // Register file memory; with its valid bits, entries not written since reset read as zero.
  logic [31:0] rf_mem [32];
  logic [31:0] rf_valid;
  logic [31:0] rd_a, rd_b;
  logic [31:0] a_val, b_val;
  logic        va, vb;

  logic [1:0]  state;
  logic [PC_BITS-1:0] pc;
  logic [15:0] program_length;
  in_item_t    item;

  logic        out_valid;
  out_item_t   out_data;

  // Divider state.
  logic [31:0] dv_q, dv_r, dv_d;
  logic [5:0]  dv_cnt;

  logic accept;
  assign in_ch.ready = (state == S_IDLE) && (!out_valid || out_ch.ready);
  assign accept = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data = out_data;

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_a <= rf_mem[in_ch.data.src1_reg];
      rd_b <= rf_mem[in_ch.data.src2_reg];
    end
  end

  // The two source values; x0 and never-written entries read zero.
  assign a_val = va ? rd_a : 32'd0;
  assign b_val = vb ? rd_b : 32'd0;

  // Execute stage.
  logic        halt_now;
  logic [PC_BITS-1:0] pc_inc, pc_br, nxt;
  logic [31:0] alu, daddr, br_q;
  logic        wr, acc, is_div;
  logic [4:0]  sh;

  assign halt_now = ({{(32-PC_BITS){1'b0}}, pc} >= {16'd0, program_length});
  assign pc_inc = pc + 1'b1;
  // Truncating divide by four of a signed offset.
  assign br_q = (item.immediate + (item.immediate[31] ? 32'sd3 : 32'sd0)) >>> 2;
  assign pc_br = pc + br_q[PC_BITS-1:0];
  assign daddr = a_val + item.immediate;
  assign is_div = (item.operation == OP_DIV) || (item.operation == OP_REM);

  always_comb begin
    alu = 32'd0;
    wr = 1'b1;
    acc = 1'b0;
    nxt = pc_inc;
    sh = 5'd0;
    case (item.operation)
      OP_LI:   alu = item.immediate;
      OP_LW, OP_SW: begin
        wr = 1'b0;
        acc = 1'b1;
      end
      OP_ADD:  alu = a_val + b_val;
      OP_AND:  alu = a_val & b_val;
      OP_MUL:  alu = a_val * b_val;
      OP_OR:   alu = a_val | b_val;
      OP_SLL: begin
        sh = b_val[4:0] & SHAMT_MASK;
        alu = a_val << sh;
      end
      OP_SRL: begin
        sh = b_val[4:0] & SHAMT_MASK;
        alu = a_val >> sh;
      end
      OP_SUB:  alu = a_val - b_val;
      OP_XOR:  alu = a_val ^ b_val;
      OP_ADDI: alu = a_val + item.immediate;
      OP_ANDI: alu = a_val & item.immediate;
      OP_ORI:  alu = a_val | item.immediate;
      OP_SLLI: begin
        sh = item.immediate[4:0] & SHAMT_MASK;
        alu = a_val << sh;
      end
      OP_SRLI: begin
        sh = item.immediate[4:0] & SHAMT_MASK;
        alu = a_val >> sh;
      end
      OP_XORI: alu = a_val ^ item.immediate;
      OP_BEQ: begin
        wr = 1'b0;
        if (a_val == b_val) nxt = pc_br;
      end
      OP_BNE: begin
        wr = 1'b0;
        if (a_val != b_val) nxt = pc_br;
      end
      default: wr = 1'b0;
    endcase
  end

  // Division result once the divider finishes.
  logic [31:0] div_res;
  logic        div_wr;
  assign div_res = (item.operation == OP_DIV) ? dv_q : dv_r;
  assign div_wr = (dv_d != 32'd0) && (item.dest_reg != 5'd0);

  logic [31:0] dv_trial;
  assign dv_trial = {dv_r[30:0], dv_q[31]} - dv_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc <= '0;
      program_length <= 16'd0;
      rf_valid <= 32'd0;
      out_valid <= 1'b0;
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      if (cfg_we) program_length <= cfg_wdata;
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            item <= in_ch.data;
            va <= rf_valid[in_ch.data.src1_reg];
            vb <= rf_valid[in_ch.data.src2_reg];
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          out_data.fetch_address <= 18'({pc, 2'b00});
          if (halt_now) begin
            out_data.data_access_valid <= 1'b0;
            out_data.data_address <= 32'd0;
            out_data.write_valid <= 1'b0;
            out_data.write_index <= 5'd0;
            out_data.write_value <= 32'd0;
            out_data.next_pc <= 16'(pc);
            out_data.halted <= 1'b1;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end else if (is_div) begin
            dv_q <= a_val;
            dv_r <= 32'd0;
            dv_d <= b_val;
            dv_cnt <= 6'd0;
            state <= S_DIV;
          end else begin
            out_data.data_access_valid <= acc;
            out_data.data_address <= acc ? daddr : 32'd0;
            out_data.write_valid <= wr && (item.dest_reg != 5'd0);
            out_data.write_index <= (wr && item.dest_reg != 5'd0) ? item.dest_reg : 5'd0;
            out_data.write_value <= (wr && item.dest_reg != 5'd0) ? alu : 32'd0;
            out_data.next_pc <= 16'(nxt);
            out_data.halted <= ({{(32-PC_BITS){1'b0}}, nxt} >= {16'd0, program_length});
            out_valid <= 1'b1;
            if (wr && item.dest_reg != 5'd0) rf_valid[item.dest_reg] <= 1'b1;
            pc <= nxt;
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          if (dv_cnt == 6'd32) begin
            out_data.data_access_valid <= 1'b0;
            out_data.data_address <= 32'd0;
            out_data.write_valid <= div_wr;
            out_data.write_index <= div_wr ? item.dest_reg : 5'd0;
            out_data.write_value <= div_wr ? div_res : 32'd0;
            out_data.next_pc <= 16'(pc_inc);
            out_data.halted <= ({{(32-PC_BITS){1'b0}}, pc_inc} >= {16'd0, program_length});
            out_valid <= 1'b1;
            if (div_wr) rf_valid[item.dest_reg] <= 1'b1;
            pc <= pc_inc;
            state <= S_IDLE;
          end else begin
            // Restoring division, one quotient bit per cycle.
            dv_cnt <= dv_cnt + 6'd1;
            if ({dv_r[31:0], dv_q[31]} >= {1'b0, dv_d}) begin
              dv_r <= dv_trial;
              dv_q <= {dv_q[30:0], 1'b1};
            end else begin
              dv_r <= {dv_r[30:0], dv_q[31]};
              dv_q <= {dv_q[30:0], 1'b0};
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Register file write port.
  always_ff @(posedge clk) begin
    if (!rst && state == S_EXEC && !halt_now && !is_div && wr && item.dest_reg != 5'd0)
      rf_mem[item.dest_reg] <= alu;
    else if (!rst && state == S_DIV && dv_cnt == 6'd32 && div_wr)
      rf_mem[item.dest_reg] <= div_res;
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !accept) else $error("item accepted while busy");
  a_x0_never_written: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.write_valid |-> out_data.write_index != 5'd0)
    else $error("write to x0 reported");
  a_halt_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && halt_now) |=> out_valid && !out_data.write_valid)
    else $error("halted item wrote a register");
  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> dv_cnt <= 6'd32) else $error("divider overran");
endmodule
